// ===== src/rwmc_pkg.sv =====
package rwmc_pkg;

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Move directions
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Wall-open bits of a cell
  localparam logic [3:0] WALL_LEFT   = 4'b0001;
  localparam logic [3:0] WALL_RIGHT  = 4'b0010;
  localparam logic [3:0] WALL_TOP    = 4'b0100;
  localparam logic [3:0] WALL_BOTTOM = 4'b1000;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [6:0] SIDE_RESET = 7'd16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] random_value;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
  } item_t;

  typedef struct packed {
    logic [5:0]  walker_col;
    logic [5:0]  walker_row;
    logic        carved;
    logic [1:0]  move_dir;
    logic [3:0]  cell_walls;
    logic        cell_seen;
    logic        done_res;
    logic [12:0] remaining;
  } result_t;

  typedef struct packed {
    logic       seen;
    logic [3:0] walls;
  } cell_t;

  // Byte modulo three: base-4 digits sum, then fold
  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] f;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    f = 3'(s[1:0]) + 3'(s[3:2]);
    if (f >= 3'd3) f = f - 3'd3;
    if (f >= 3'd3) f = f - 3'd3;
    return f[1:0];
  endfunction

  // Wall bit on the side of the walker's cell
  function automatic logic [3:0] wall_here(input logic [1:0] d);
    logic [3:0] b;
    case (d)
      DIR_LEFT:  b = WALL_LEFT;
      DIR_RIGHT: b = WALL_RIGHT;
      DIR_UP:    b = WALL_TOP;
      default:   b = WALL_BOTTOM;
    endcase
    return b;
  endfunction

  // Wall bit on the side of the entered cell
  function automatic logic [3:0] wall_there(input logic [1:0] d);
    logic [3:0] b;
    case (d)
      DIR_LEFT:  b = WALL_RIGHT;
      DIR_RIGHT: b = WALL_LEFT;
      DIR_UP:    b = WALL_BOTTOM;
      default:   b = WALL_TOP;
    endcase
    return b;
  endfunction

endpackage

// ===== src/rwmc_cell_mem.sv =====
module rwmc_cell_mem import rwmc_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  cell_t             wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] ra_addr,
  input  logic [ADDR_W-1:0] rb_addr,
  output cell_t             ra_data,
  output cell_t             rb_data
);

  cell_t mem [DEPTH];

  // Write one word, read two with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      ra_data <= mem[ra_addr];
      rb_data <= mem[rb_addr];
    end
  end

endmodule

// ===== src/rwmc_move_pick.sv =====
module rwmc_move_pick import rwmc_pkg::*; #(
  parameter int WK_W = 6
) (
  input  logic [WK_W-1:0] wx,
  input  logic [WK_W-1:0] wy,
  input  logic [6:0]      w,
  input  logic [6:0]      h,
  input  logic [7:0]      rnd,
  output logic [1:0]      dir,
  output logic [WK_W-1:0] nx,
  output logic [WK_W-1:0] ny
);

  logic [3:0] avail;
  logic [2:0] n;
  logic [1:0] k;
  logic [2:0] cnt;

  // Flag in-grid neighbors in the order left, right, up, down
  always_comb begin
    avail[0] = (wx != '0);
    avail[1] = ((9'(wx) + 9'd1) < 9'(w));
    avail[2] = (wy != '0);
    avail[3] = ((9'(wy) + 9'd1) < 9'(h));
    n = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);
  end

  // Reduce the random byte modulo the neighbor count
  always_comb begin
    case (n)
      3'd2:    k = {1'b0, rnd[0]};
      3'd3:    k = mod3(rnd);
      3'd4:    k = rnd[1:0];
      default: k = 2'd0;
    endcase
  end

  // Take the k-th available neighbor
  always_comb begin
    dir = DIR_LEFT;
    cnt = 3'd0;
    for (int d = 0; d < 4; d++) begin
      if (avail[d]) begin
        if (cnt == {1'b0, k}) dir = 2'(d);
        cnt = cnt + 3'd1;
      end
    end
  end

  // Form the target cell
  always_comb begin
    nx = wx;
    ny = wy;
    case (dir)
      DIR_LEFT:  nx = wx - WK_W'(1);
      DIR_RIGHT: nx = wx + WK_W'(1);
      DIR_UP:    ny = wy - WK_W'(1);
      default:   ny = wy + WK_W'(1);
    endcase
  end

endmodule

// ===== src/random_walk_maze_carver_core.sv =====
// Maze carver by random walk over a cell store of MAX_SIDE x MAX_SIDE words
// (4096 by default), one cell per word, with registered read data. After reset
// the block is busy while it sweeps the store to zero. A read returns the cell
// from one store read; a step that enters a visited cell reads the current and
// target cells, then moves the walker; a step that carves does one store read,
// then two write-backs through the single write port; a step after the walk is
// done or an unused kind strobes straight from the accepting edge; and a start
// sweeps the whole store once before it marks the start cell. A new item can be
// taken at the edge that ends the strobe cycle. The strobe is not held off: every
// result is on the result port for exactly one cycle and must be taken then.
module random_walk_maze_carver_core import rwmc_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  output logic       strobe,
  output result_t    result,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int WK_W   = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] SIDE_A   = ADDR_W'(MAX_SIDE);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);
  localparam logic [8:0]        MAX_SIDE9 = 9'(MAX_SIDE);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SEED  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_WR_A  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic              seed_pend;
  logic [6:0]        grid_width;
  logic [6:0]        grid_height;
  logic [WK_W-1:0]   walker_x;
  logic [WK_W-1:0]   walker_y;
  logic [CNT_W-1:0]  count;
  logic [1:0]        pend_dir;
  logic [WK_W-1:0]   pend_x;
  logic [WK_W-1:0]   pend_y;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;

  logic [6:0]        w_eff;
  logic [6:0]        h_eff;
  logic [5:0]        col_clamp;
  logic [5:0]        row_clamp;
  logic [1:0]        pick_dir;
  logic [WK_W-1:0]   pick_x;
  logic [WK_W-1:0]   pick_y;
  logic              accept;
  logic [13:0]       area;
  logic [CNT_W-1:0]  count_dec;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cell_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] ra_addr;
  logic [ADDR_W-1:0] rb_addr;
  cell_t             ra_data;
  cell_t             rb_data;

  function automatic logic [6:0] eff_side(input logic [6:0] v);
    logic [6:0] r;
    if (v < 7'd2) r = 7'd2;
    else if ({2'b00, v} > MAX_SIDE9) r = 7'(MAX_SIDE9);
    else r = v;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [WK_W-1:0] x,
                                                  input logic [WK_W-1:0] y);
    return ADDR_W'(ADDR_W'(y) * SIDE_A + ADDR_W'(x));
  endfunction

  // Clamp sizes and incoming coordinates to the grid
  always_comb begin
    w_eff = eff_side(grid_width);
    h_eff = eff_side(grid_height);
    col_clamp = ({1'b0, item.cell_col} >= w_eff) ? 6'(w_eff - 7'd1) : item.cell_col;
    row_clamp = ({1'b0, item.cell_row} >= h_eff) ? 6'(h_eff - 7'd1) : item.cell_row;
    area = 14'(w_eff) * 14'(h_eff);
    count_dec = count - CNT_W'(1);
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  rwmc_move_pick #(
    .WK_W (WK_W)
  ) u_pick (
    .wx  (walker_x),
    .wy  (walker_y),
    .w   (w_eff),
    .h   (h_eff),
    .rnd (item.random_value),
    .dir (pick_dir),
    .nx  (pick_x),
    .ny  (pick_y)
  );

  // Store read at accept: current and target cell, or the cell to read
  always_comb begin
    mem_re  = accept && (((item.kind == KIND_STEP) && (count != '0)) ||
                         (item.kind == KIND_READ));
    ra_addr = (item.kind == KIND_READ) ? cell_addr(WK_W'(col_clamp), WK_W'(row_clamp))
                                       : cell_addr(walker_x, walker_y);
    rb_addr = cell_addr(pick_x, pick_y);
  end

  // Store write: sweep, seed, carve into target, then open current cell
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SEED: begin
        mem_we         = 1'b1;
        mem_waddr      = cell_addr(walker_x, walker_y);
        mem_wdata.seen = 1'b1;
      end
      ST_EVAL: begin
        mem_we          = !rb_data.seen;
        mem_waddr       = b_addr;
        mem_wdata.seen  = 1'b1;
        mem_wdata.walls = rb_data.walls | wall_there(pend_dir);
      end
      ST_WR_A: begin
        mem_we          = 1'b1;
        mem_waddr       = a_addr;
        mem_wdata.seen  = ra_data.seen;
        mem_wdata.walls = ra_data.walls | wall_here(pend_dir);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  rwmc_cell_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // Sequencer, walker state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      seed_pend   <= 1'b0;
      grid_width  <= SIDE_RESET;
      grid_height <= SIDE_RESET;
      walker_x    <= '0;
      walker_y    <= '0;
      count       <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;

      // Take configuration beats
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default:         grid_width <= grid_width;
        endcase
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_A) begin
            clr_addr  <= '0;
            seed_pend <= 1'b0;
            state     <= seed_pend ? ST_SEED : ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            result.walker_col <= 6'({8'd0, walker_x});
            result.walker_row <= 6'({8'd0, walker_y});
            result.carved     <= 1'b0;
            result.move_dir   <= DIR_LEFT;
            result.cell_walls <= '0;
            result.cell_seen  <= 1'b0;
            result.done_res   <= (count == '0);
            result.remaining  <= 13'(count);
            pend_dir          <= pick_dir;
            pend_x            <= pick_x;
            pend_y            <= pick_y;
            a_addr            <= ra_addr;
            b_addr            <= rb_addr;
            case (item.kind)
              KIND_START: begin
                walker_x  <= WK_W'(col_clamp);
                walker_y  <= WK_W'(row_clamp);
                count     <= CNT_W'(area - 14'd1);
                seed_pend <= 1'b1;
                state     <= ST_CLEAR;
              end
              KIND_STEP: begin
                if (count != '0) state <= ST_EVAL;
                else strobe <= 1'b1;
              end
              KIND_READ: begin
                state <= ST_READ;
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end

        ST_SEED: begin
          result.walker_col <= 6'({8'd0, walker_x});
          result.walker_row <= 6'({8'd0, walker_y});
          result.done_res   <= (count == '0);
          result.remaining  <= 13'(count);
          strobe            <= 1'b1;
          state             <= ST_IDLE;
        end

        ST_EVAL: begin
          // Move the walker; carve only into an unvisited cell
          walker_x          <= pend_x;
          walker_y          <= pend_y;
          result.walker_col <= 6'({8'd0, pend_x});
          result.walker_row <= 6'({8'd0, pend_y});
          result.move_dir   <= pend_dir;
          if (!rb_data.seen) begin
            count             <= count_dec;
            result.carved     <= 1'b1;
            result.done_res   <= (count_dec == '0);
            result.remaining  <= 13'(count_dec);
            state             <= ST_WR_A;
          end else begin
            strobe <= 1'b1;
            state  <= ST_IDLE;
          end
        end

        ST_WR_A: begin
          strobe <= 1'b1;
          state  <= ST_IDLE;
        end

        ST_READ: begin
          result.cell_walls <= ra_data.walls;
          result.cell_seen  <= ra_data.seen;
          strobe            <= 1'b1;
          state             <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
